// File: src/scm_pkg.sv
package scm_pkg;

  localparam int unsigned MaxDimDefault = 1024;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_ENTRY = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PARAM = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] CFG_NUM_ROWS  = 2'd0;
  localparam logic [1:0] CFG_NUM_COLS  = 2'd1;
  localparam logic [1:0] CFG_SYMMETRY  = 2'd2;
  localparam logic [1:0] CFG_UNIT_DIAG = 2'd3;

  localparam logic [1:0] SYM_UPPER = 2'd1;
  localparam logic [1:0] SYM_LOWER = 2'd2;

  localparam logic [63:0] DefaultNan = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;

  typedef enum logic {
    FOP_MUL = 1'b0,
    FOP_ADD = 1'b1
  } fop_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  vec_index;
    logic [9:0]  row_index;
    logic [9:0]  col_index;
    logic [63:0] data_bits;
  } in_item_t;

  typedef struct packed {
    logic [63:0] y_value;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        start;
    fop_e        op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

endpackage

// File: src/scm_ram.sv
module scm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/scm_fpu.sv
module scm_fpu import scm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fpu_req_t req_i,
  output fpu_rsp_t rsp_o
);

  typedef enum logic [6:0] {
    F_IDLE   = 7'b0000001,
    F_MUL    = 7'b0000010,
    F_ALIGN  = 7'b0000100,
    F_NORM   = 7'b0001000,
    F_DENORM = 7'b0010000,
    F_ROUND  = 7'b0100000,
    F_DONE   = 7'b1000000
  } fstate_e;

  fstate_e            state_q, state_d;
  logic [127:0]       m_q, m_d, sm_q, sm_d, pp_q, pp_d;
  logic [52:0]        ma_q, ma_d, mb_q, mb_d;
  logic [2:0]         k_q, k_d;
  logic               sign_q, sign_d, sub_q, sub_d;
  logic signed [13:0] scale_q, scale_d, be_q, be_d;
  logic [10:0]        d_q, d_d, dsh_q, dsh_d;
  logic [63:0]        res_q, res_d;

  logic        sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, a_big;
  logic [10:0] ea, eb;
  logic [52:0] fa, fb;
  logic [26:0] opa, opb;
  logic [53:0] prod;
  logic signed [13:0] be_w, be_f;
  logic [52:0] mant;
  logic [53:0] mant_sum;
  logic [52:0] mant_f;
  logic        rnd_up;

  function automatic logic [127:0] shr8(input logic [127:0] v);
    shr8 = {8'b0, v[127:8]} | {127'b0, |v[7:0]};
  endfunction

  function automatic logic [127:0] shr1(input logic [127:0] v);
    shr1 = {1'b0, v[127:1]} | {127'b0, v[0]};
  endfunction

  always_comb begin
    sa     = req_i.a[63];
    sb     = req_i.b[63];
    nan_a  = (req_i.a[62:52] == 11'h7FF) && (req_i.a[51:0] != '0);
    nan_b  = (req_i.b[62:52] == 11'h7FF) && (req_i.b[51:0] != '0);
    inf_a  = (req_i.a[62:52] == 11'h7FF) && (req_i.a[51:0] == '0);
    inf_b  = (req_i.b[62:52] == 11'h7FF) && (req_i.b[51:0] == '0);
    zero_a = (req_i.a[62:0] == '0);
    zero_b = (req_i.b[62:0] == '0);
    ea     = (req_i.a[62:52] == '0) ? 11'd1 : req_i.a[62:52];
    eb     = (req_i.b[62:52] == '0) ? 11'd1 : req_i.b[62:52];
    fa     = {req_i.a[62:52] != '0, req_i.a[51:0]};
    fb     = {req_i.b[62:52] != '0, req_i.b[51:0]};
    a_big  = req_i.a[62:0] >= req_i.b[62:0];
  end

  always_comb begin
    case (k_q)
      3'd0: begin
        opa = ma_q[26:0];
        opb = mb_q[26:0];
      end
      3'd1: begin
        opa = ma_q[26:0];
        opb = {1'b0, mb_q[52:27]};
      end
      3'd2: begin
        opa = {1'b0, ma_q[52:27]};
        opb = mb_q[26:0];
      end
      default: begin
        opa = {1'b0, ma_q[52:27]};
        opb = {1'b0, mb_q[52:27]};
      end
    endcase
    prod = opa * opb;
  end

  always_comb begin
    be_w     = scale_q + 14'sd1150;
    mant     = m_q[127:75];
    rnd_up   = m_q[74] & ((|m_q[73:0]) | mant[0]);
    mant_sum = {1'b0, mant} + {53'b0, rnd_up};
    if (mant_sum[53]) begin
      mant_f = mant_sum[53:1];
      be_f   = be_q + 14'sd1;
    end else begin
      mant_f = mant_sum[52:0];
      be_f   = be_q;
    end
  end

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    sm_d    = sm_q;
    pp_d    = pp_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    k_d     = k_q;
    sign_d  = sign_q;
    sub_d   = sub_q;
    scale_d = scale_q;
    be_d    = be_q;
    d_d     = d_q;
    dsh_d   = dsh_q;
    res_d   = res_q;
    case (state_q)
      F_IDLE: begin
        if (req_i.start) begin
          state_d = F_DONE;
          if (req_i.op == FOP_MUL) begin
            if (nan_a) begin
              res_d = req_i.a | QuietBit;
            end else if (nan_b) begin
              res_d = req_i.b | QuietBit;
            end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
              res_d = DefaultNan;
            end else if (inf_a || inf_b) begin
              res_d = {sa ^ sb, 11'h7FF, 52'b0};
            end else if (zero_a || zero_b) begin
              res_d = {sa ^ sb, 63'b0};
            end else begin
              ma_d    = fa;
              mb_d    = fb;
              sign_d  = sa ^ sb;
              scale_d = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 14'sd2150;
              m_d     = '0;
              k_d     = '0;
              state_d = F_MUL;
            end
          end else begin
            if (nan_a) begin
              res_d = req_i.a | QuietBit;
            end else if (nan_b) begin
              res_d = req_i.b | QuietBit;
            end else if (inf_a && inf_b && (sa != sb)) begin
              res_d = DefaultNan;
            end else if (inf_a) begin
              res_d = req_i.a;
            end else if (inf_b) begin
              res_d = req_i.b;
            end else if (zero_a && zero_b) begin
              res_d = {sa & sb, 63'b0};
            end else if (zero_a) begin
              res_d = req_i.b;
            end else if (zero_b) begin
              res_d = req_i.a;
            end else begin
              sub_d = sa != sb;
              if (a_big) begin
                m_d     = {3'b0, fa, 72'b0};
                sm_d    = {3'b0, fb, 72'b0};
                sign_d  = sa;
                scale_d = $signed({3'b0, ea}) - 14'sd1147;
                d_d     = ea - eb;
              end else begin
                m_d     = {3'b0, fb, 72'b0};
                sm_d    = {3'b0, fa, 72'b0};
                sign_d  = sb;
                scale_d = $signed({3'b0, eb}) - 14'sd1147;
                d_d     = eb - ea;
              end
              state_d = F_ALIGN;
            end
          end
        end
      end
      F_MUL: begin
        case (k_q)
          3'd0: pp_d = {74'b0, prod};
          3'd3: pp_d = {20'b0, prod, 54'b0};
          default: pp_d = {47'b0, prod, 27'b0};
        endcase
        if (k_q != 3'd0) begin
          m_d = m_q + pp_q;
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) begin
          state_d = F_NORM;
        end
      end
      F_ALIGN: begin
        if (d_q == '0) begin
          m_d     = sub_q ? (m_q - sm_q) : (m_q + sm_q);
          state_d = F_NORM;
        end else if (d_q >= 11'd128) begin
          sm_d = {127'b0, |sm_q};
          d_d  = '0;
        end else if (d_q >= 11'd8) begin
          sm_d = shr8(sm_q);
          d_d  = d_q - 11'd8;
        end else begin
          sm_d = shr1(sm_q);
          d_d  = d_q - 11'd1;
        end
      end
      F_NORM: begin
        if (m_q == '0) begin
          res_d   = '0;
          state_d = F_DONE;
        end else if (m_q[127]) begin
          if (be_w >= 14'sd1) begin
            be_d    = be_w;
            state_d = F_ROUND;
          end else begin
            be_d    = 14'sd1;
            dsh_d   = 11'(14'sd1 - be_w);
            state_d = F_DENORM;
          end
        end else if (m_q[127:120] == '0) begin
          m_d     = {m_q[119:0], 8'b0};
          scale_d = scale_q - 14'sd8;
        end else begin
          m_d     = {m_q[126:0], 1'b0};
          scale_d = scale_q - 14'sd1;
        end
      end
      F_DENORM: begin
        if (dsh_q == '0) begin
          state_d = F_ROUND;
        end else if (dsh_q >= 11'd128) begin
          m_d   = {127'b0, |m_q};
          dsh_d = '0;
        end else if (dsh_q >= 11'd8) begin
          m_d   = shr8(m_q);
          dsh_d = dsh_q - 11'd8;
        end else begin
          m_d   = shr1(m_q);
          dsh_d = dsh_q - 11'd1;
        end
      end
      F_ROUND: begin
        if (be_f >= 14'sd2047) begin
          res_d = {sign_q, 11'h7FF, 52'b0};
        end else begin
          res_d = {sign_q, mant_f[52] ? be_f[10:0] : 11'd0, mant_f[51:0]};
        end
        state_d = F_DONE;
      end
      F_DONE: begin
        state_d = F_IDLE;
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    sm_q    <= sm_d;
    pp_q    <= pp_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    k_q     <= k_d;
    sign_q  <= sign_d;
    sub_q   <= sub_d;
    scale_q <= scale_d;
    be_q    <= be_d;
    d_q     <= d_d;
    dsh_q   <= dsh_d;
    res_q   <= res_d;
  end

  assign rsp_o.done = (state_q == F_DONE);
  assign rsp_o.res  = res_q;

endmodule

// File: src/sparse_csc_matvec_accumulate_core.sv
// Channel  | Signals                                   | Direction
// cfg      | cfg_valid_i cfg_ready_o cfg_index_i/data  | in, always ready
// in       | in_valid_i in_stall_o in_data_i           | in, one command per transfer
// out      | out_valid_o out_stall_i out_data_o        | out, one result per command
// Start clears y, or with the unit diagonal on a square matrix copies x
// into y. Entry: one or two accumulates, each a multiply and an add in the
// shared multi-cycle double multiply/add unit.
// Reset clears control only; x and y memories hold no reset value.
// A pending result holds the next command until it is transferred.
module sparse_csc_matvec_accumulate_core import scm_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(MAX_DIM);

  typedef enum logic [9:0] {
    T_IDLE     = 10'b0000000001,
    T_RDWAIT   = 10'b0000000010,
    T_CLR      = 10'b0000000100,
    T_CP_RD    = 10'b0000001000,
    T_CP_WR    = 10'b0000010000,
    T_X_RD     = 10'b0000100000,
    T_MUL_GO   = 10'b0001000000,
    T_MUL_WAIT = 10'b0010000000,
    T_ADD_GO   = 10'b0100000000,
    T_ADD_WAIT = 10'b1000000000
  } tstate_e;

  tstate_e     state_q, state_d;
  in_item_t    item_q, item_d;
  logic [10:0] cnt_q, cnt_d;
  logic        pass_q, pass_d, two_q, two_d;
  logic [1:0]  st_q, st_d;
  logic [63:0] p_q, p_d;
  logic [10:0] rows_q, cols_q;
  logic [1:0]  sym_q;
  logic        unit_q;
  logic        out_valid_q;
  out_item_t   out_q, out_nxt;
  logic        out_load;

  logic          accept, bad_dims, square, sym_on, last;
  logic [9:0]    tgt_idx, src_idx;
  logic          x_we, y_we;
  logic [AW-1:0] x_waddr, x_raddr, y_waddr, y_raddr;
  logic [63:0]   x_wdata, x_rdata, y_wdata, y_rdata;
  fpu_req_t      fpu_req;
  fpu_rsp_t      fpu_rsp;

  scm_ram #(.DEPTH(MAX_DIM), .WIDTH(64)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (x_waddr),
    .wdata_i (x_wdata),
    .raddr_i (x_raddr),
    .rdata_o (x_rdata)
  );

  scm_ram #(.DEPTH(MAX_DIM), .WIDTH(64)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (y_waddr),
    .wdata_i (y_wdata),
    .raddr_i (y_raddr),
    .rdata_o (y_rdata)
  );

  scm_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .rsp_o  (fpu_rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !((state_q == T_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign bad_dims    = (rows_q == '0) || (32'(rows_q) > MAX_DIM) ||
                       (cols_q == '0) || (32'(cols_q) > MAX_DIM);
  assign square      = rows_q == cols_q;
  assign sym_on      = ((sym_q == SYM_UPPER) || (sym_q == SYM_LOWER)) && square;
  assign last        = cnt_q == (rows_q - 11'd1);
  assign tgt_idx     = pass_q ? item_q.col_index : item_q.row_index;
  assign src_idx     = pass_q ? item_q.row_index : item_q.col_index;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    two_d       = two_q;
    st_d        = st_q;
    p_d         = p_q;
    out_load    = 1'b0;
    out_nxt     = '{y_value: '0, status: st_q};
    x_we        = 1'b0;
    x_waddr     = AW'(in_data_i.vec_index);
    x_wdata     = in_data_i.data_bits;
    x_raddr     = (state_q == T_X_RD) ? AW'(src_idx) : AW'(cnt_q);
    y_we        = 1'b0;
    y_waddr     = AW'(cnt_q);
    y_wdata     = '0;
    y_raddr     = (state_q == T_IDLE) ? AW'(in_data_i.vec_index) : AW'(tgt_idx);
    fpu_req     = '{start: 1'b0, op: FOP_MUL, a: item_q.data_bits, b: x_rdata};
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          if (bad_dims) begin
            out_load = 1'b1;
            out_nxt  = '{y_value: '0, status: ST_PARAM};
          end else begin
            case (cmd_e'(in_data_i.cmd))
              CMD_LOAD: begin
                out_load = 1'b1;
                if ({1'b0, in_data_i.vec_index} >= cols_q) begin
                  out_nxt = '{y_value: '0, status: ST_RANGE};
                end else begin
                  x_we    = 1'b1;
                  out_nxt = '{y_value: '0, status: ST_OK};
                end
              end
              CMD_START: begin
                cnt_d = '0;
                st_d  = (unit_q && !square) ? ST_PARAM : ST_OK;
                state_d = (unit_q && square) ? T_CP_RD : T_CLR;
              end
              CMD_ENTRY: begin
                pass_d = 1'b0;
                two_d  = sym_on && (in_data_i.row_index != in_data_i.col_index);
                st_d   = ST_OK;
                if (({1'b0, in_data_i.row_index} >= rows_q) ||
                    ({1'b0, in_data_i.col_index} >= cols_q)) begin
                  out_load = 1'b1;
                  out_nxt  = '{y_value: '0, status: ST_RANGE};
                end else if (sym_on &&
                             (in_data_i.row_index != in_data_i.col_index) &&
                             !(((sym_q == SYM_UPPER) &&
                                (in_data_i.col_index > in_data_i.row_index)) ||
                               ((sym_q == SYM_LOWER) &&
                                (in_data_i.col_index < in_data_i.row_index)))) begin
                  out_load = 1'b1;
                  out_nxt  = '{y_value: '0, status: ST_OK};
                end else begin
                  state_d = T_X_RD;
                end
              end
              default: begin
                if ({1'b0, in_data_i.vec_index} >= rows_q) begin
                  out_load = 1'b1;
                  out_nxt  = '{y_value: '0, status: ST_RANGE};
                end else begin
                  state_d = T_RDWAIT;
                end
              end
            endcase
          end
        end
      end
      T_RDWAIT: begin
        out_load = 1'b1;
        out_nxt  = '{y_value: y_rdata, status: ST_OK};
        state_d  = T_IDLE;
      end
      T_CLR: begin
        y_we  = 1'b1;
        cnt_d = cnt_q + 11'd1;
        if (last) begin
          out_load = 1'b1;
          state_d  = T_IDLE;
        end
      end
      T_CP_RD: begin
        state_d = T_CP_WR;
      end
      T_CP_WR: begin
        y_we    = 1'b1;
        y_wdata = x_rdata;
        cnt_d   = cnt_q + 11'd1;
        if (last) begin
          out_load = 1'b1;
          state_d  = T_IDLE;
        end else begin
          state_d = T_CP_RD;
        end
      end
      T_X_RD: begin
        state_d = T_MUL_GO;
      end
      T_MUL_GO: begin
        fpu_req.start = 1'b1;
        state_d       = T_MUL_WAIT;
      end
      T_MUL_WAIT: begin
        if (fpu_rsp.done) begin
          p_d     = fpu_rsp.res;
          state_d = T_ADD_GO;
        end
      end
      T_ADD_GO: begin
        fpu_req = '{start: 1'b1, op: FOP_ADD, a: y_rdata, b: p_q};
        state_d = T_ADD_WAIT;
      end
      T_ADD_WAIT: begin
        if (fpu_rsp.done) begin
          y_we    = 1'b1;
          y_waddr = AW'(tgt_idx);
          y_wdata = fpu_rsp.res;
          if (two_q && !pass_q) begin
            pass_d  = 1'b1;
            state_d = T_X_RD;
          end else begin
            out_load = 1'b1;
            state_d  = T_IDLE;
          end
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
      rows_q      <= 11'd1024;
      cols_q      <= 11'd1024;
      sym_q       <= '0;
      unit_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_NUM_ROWS:  rows_q <= cfg_data_i;
          CFG_NUM_COLS:  cols_q <= cfg_data_i;
          CFG_SYMMETRY:  sym_q  <= cfg_data_i[1:0];
          CFG_UNIT_DIAG: unit_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cnt_q  <= cnt_d;
    pass_q <= pass_d;
    two_q  <= two_d;
    st_q   <= st_d;
    p_q    <= p_d;
    if (out_load) begin
      out_q <= out_nxt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/scm_checker.sv
module scm_checker import scm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK) || (out_data_o.status == ST_PARAM) ||
                    (out_data_o.status == ST_RANGE))
    else $error("unknown status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.y_value == '0)
    else $error("error result carries data");

  // a transfer either answers at once or blocks the next command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o || in_stall_o)
    else $error("command neither answered nor held");

endmodule

bind sparse_csc_matvec_accumulate_core scm_checker u_scm_checker (.*);
